// ----- sv/tss_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tss_pkg
// shared widths, codes, types and the divider step for the scanline span block
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int FRAC_BITS = 8;
    localparam int CW        = 24;
    localparam int SW        = 16;
    localparam int YW        = SW + FRAC_BITS;
    localparam int DW        = ((CW > YW) ? CW : YW) + 1;
    localparam int PW        = 2 * DW - 1;
    localparam int QW        = DW;
    localparam int NE        = 3;
    localparam int AW        = 3;
    localparam int QDEPTH    = 4;

    typedef enum logic [AW-1:0] {
        REG_AX,
        REG_AY,
        REG_BX,
        REG_BY,
        REG_CX,
        REG_CY
    } t_reg;

    typedef enum logic [1:0] {
        EK_NONE,
        EK_HORZ,
        EK_CROSS
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic signed [CW-1:0]   xa;
        logic signed [CW-1:0]   xb;
        logic                   neg;
        logic [PW-1:0]          rem;
        logic [DW-1:0]          den;
        logic [QW-1:0]          quo;
    } t_edge;

    typedef t_edge [NE-1:0] t_item;

    // one restoring step for quotient bit b of every edge
    function automatic t_item div_step(t_item it, int b);
        t_item         res;
        logic [PW-1:0] sh;
        res = it;
        for (int e = 0; e < NE; e++) begin
            sh = PW'(it[e].den) << b;
            if (it[e].rem >= sh) begin
                res[e].rem    = it[e].rem - sh;
                res[e].quo[b] = 1'b1;
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- sv/tss_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tss_front
// vertex registers, edge classification and crossing product per row
// ----------------------------------------------------------------------------
module tss_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [tss_pkg::AW-1:0]      i_cfg_addr,
    input  wire logic [tss_pkg::CW-1:0]      i_cfg_data,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [tss_pkg::SW-1:0]      i_s_tdata,
    input  wire logic                        i_q_full,
    output logic                             o_push,
    output tss_pkg::t_item                   o_item
);

    localparam int DW = tss_pkg::DW;
    localparam int CW = tss_pkg::CW;
    localparam int SW = tss_pkg::SW;

    logic signed [CW-1:0] r_vx [tss_pkg::NE];
    logic signed [CW-1:0] r_vy [tss_pkg::NE];
    logic                 r_valid;
    tss_pkg::t_item       r_item;
    tss_pkg::t_item       n_item;

    logic signed [DW-1:0] yy;
    logic signed [DW-1:0] x1, y1, x2, y2, dy, dx, dd;
    logic [DW-1:0]        ady, adx, add;
    logic [2*DW-1:0]      prod;
    logic                 take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < tss_pkg::NE; k++) begin
                r_vx[k] <= '0;
                r_vy[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tss_pkg::REG_AX: r_vx[0] <= i_cfg_data;
                tss_pkg::REG_AY: r_vy[0] <= i_cfg_data;
                tss_pkg::REG_BX: r_vx[1] <= i_cfg_data;
                tss_pkg::REG_BY: r_vy[1] <= i_cfg_data;
                tss_pkg::REG_CX: r_vx[2] <= i_cfg_data;
                tss_pkg::REG_CY: r_vy[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        yy = {{(DW-SW){i_s_tdata[SW-1]}}, i_s_tdata} <<< tss_pkg::FRAC_BITS;
        x1 = '0; y1 = '0; x2 = '0; y2 = '0;
        dy = '0; dx = '0; dd = '0;
        ady = '0; adx = '0; add = '0; prod = '0;
        for (int k = 0; k < tss_pkg::NE; k++) begin
            x1   = DW'(r_vx[k]);
            y1   = DW'(r_vy[k]);
            x2   = DW'(r_vx[(k == tss_pkg::NE-1) ? 0 : k+1]);
            y2   = DW'(r_vy[(k == tss_pkg::NE-1) ? 0 : k+1]);
            dy   = yy - y1;
            dx   = x2 - x1;
            dd   = y2 - y1;
            ady  = dy[DW-1] ? DW'(-dy) : DW'(dy);
            adx  = dx[DW-1] ? DW'(-dx) : DW'(dx);
            add  = dd[DW-1] ? DW'(-dd) : DW'(dd);
            prod = ady * adx;
            n_item[k].xa  = r_vx[k];
            n_item[k].xb  = r_vx[(k == tss_pkg::NE-1) ? 0 : k+1];
            n_item[k].neg = dy[DW-1] ^ dx[DW-1] ^ dd[DW-1];
            n_item[k].rem = prod[tss_pkg::PW-1:0];
            n_item[k].den = add;
            n_item[k].quo = '0;
            if (dd == '0) begin
                n_item[k].kind = (y1 == yy) ? tss_pkg::EK_HORZ : tss_pkg::EK_NONE;
            end else if ((yy >= y1 && yy <= y2) || (yy >= y2 && yy <= y1)) begin
                n_item[k].kind = tss_pkg::EK_CROSS;
            end else begin
                n_item[k].kind = tss_pkg::EK_NONE;
            end
        end
    end

    assign o_s_tready = !r_valid || !i_q_full;
    assign take       = i_s_tvalid && o_s_tready;
    assign o_push     = r_valid && !i_q_full;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

// ----- sv/tss_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tss_queue
// short fifo between front and back
// ----------------------------------------------------------------------------
module tss_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire tss_pkg::t_item  i_item,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output tss_pkg::t_item       o_item
);

    localparam int PTRW = $clog2(tss_pkg::QDEPTH);

    tss_pkg::t_item   r_mem [tss_pkg::QDEPTH];
    logic [PTRW-1:0]  r_wptr;
    logic [PTRW-1:0]  r_rptr;
    logic [PTRW:0]    r_count;
    logic             do_pop;

    assign o_full  = (r_count == (PTRW+1)'(tss_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + 1'b1;
            if (do_pop) r_rptr <= r_rptr + 1'b1;
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- sv/tss_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tss_back
// pipelined divide per edge, span min and max, output register
// ----------------------------------------------------------------------------
module tss_back (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_q_valid,
    input  wire tss_pkg::t_item           i_q_item,
    output logic                          o_pop,
    output logic                          o_m_tvalid,
    input  wire logic                     i_m_tready,
    output logic                          o_found,
    output logic signed [tss_pkg::CW-1:0] o_left,
    output logic signed [tss_pkg::CW-1:0] o_right
);

    localparam int QW = tss_pkg::QW;
    localparam int CW = tss_pkg::CW;

    tss_pkg::t_item       r_st [QW];
    logic [QW-1:0]        r_vld;
    logic                 ce;
    logic                 r_out_valid;
    logic                 r_found;
    logic signed [CW-1:0] r_left;
    logic signed [CW-1:0] r_right;

    logic                 n_found;
    logic signed [CW-1:0] n_left;
    logic signed [CW-1:0] n_right;
    logic signed [CW:0]   sq;
    logic signed [CW-1:0] cand [2*tss_pkg::NE];
    logic                 cval [2*tss_pkg::NE];

    assign ce    = !r_out_valid || i_m_tready;
    assign o_pop = ce && i_q_valid;

    for (genvar s = 0; s < QW; s++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (ce) begin
                if (s == 0) r_vld[s] <= i_q_valid;
                else        r_vld[s] <= r_vld[(s == 0) ? 0 : s-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (ce) begin
                if (s == 0) r_st[s] <= tss_pkg::div_step(i_q_item, QW-1-s);
                else        r_st[s] <= tss_pkg::div_step(r_st[(s == 0) ? 0 : s-1], QW-1-s);
            end
        end
    end

    always_comb begin
        sq = '0;
        for (int e = 0; e < tss_pkg::NE; e++) begin
            sq = r_st[QW-1][e].neg ? (CW+1)'(-$signed({1'b0, r_st[QW-1][e].quo}))
                                   : (CW+1)'($signed({1'b0, r_st[QW-1][e].quo}));
            cand[2*e]   = (r_st[QW-1][e].kind == tss_pkg::EK_CROSS)
                        ? CW'((CW+1)'(r_st[QW-1][e].xa) + sq) : r_st[QW-1][e].xa;
            cand[2*e+1] = r_st[QW-1][e].xb;
            cval[2*e]   = (r_st[QW-1][e].kind != tss_pkg::EK_NONE);
            cval[2*e+1] = (r_st[QW-1][e].kind == tss_pkg::EK_HORZ);
        end
        n_found = 1'b0;
        n_left  = '0;
        n_right = '0;
        for (int c = 0; c < 2*tss_pkg::NE; c++) begin
            if (cval[c]) begin
                if (!n_found || cand[c] < n_left)  n_left  = cand[c];
                if (!n_found || cand[c] > n_right) n_right = cand[c];
                n_found = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ce) begin
            r_out_valid <= r_vld[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_found <= n_found;
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_found    = r_found;
    assign o_left     = r_left;
    assign o_right    = r_right;

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_found) |-> (r_left <= r_right))
        else $error("span left beyond right");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_found) |-> (r_left == '0 && r_right == '0))
        else $error("empty span with nonzero x");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!ce) |=> $stable(r_vld))
        else $error("divider moved while stalled");

endmodule
`default_nettype wire

// ----- sv/triangle_scanline_span_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_scanline_span_top
// span of a loaded triangle on an integer scanline row
// ----------------------------------------------------------------------------
// an input beat passes the front stage register, the queue, one divider stage
//   per quotient bit and the output register; one row per cycle is accepted
//   unless the output stalls, set by the fully pipelined per-edge divider
// reset: synchronous, clears vertex registers, queue and pipeline valids
module triangle_scanline_span_top (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [tss_pkg::AW-1:0]   i_cfg_addr,
    input  wire logic [tss_pkg::CW-1:0]   i_cfg_data,
    input  wire logic                     i_s_tvalid,
    output logic                          o_s_tready,
    input  wire logic [15:0]              i_s_tdata,   // scanline_y
    output logic                          o_m_tvalid,
    input  wire logic                     i_m_tready,
    output logic [47:0]                   o_m_tdata,   // span_left, span_right
    output logic                          o_m_tuser    // span_found
);

    tss_pkg::t_item       fq_item;
    tss_pkg::t_item       qb_item;
    logic                 push, full, pop, qvalid;
    logic signed [tss_pkg::CW-1:0] left, right;

    tss_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_q_full   (full),
        .o_push     (push),
        .o_item     (fq_item)
    );

    tss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (fq_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (qvalid),
        .o_item  (qb_item)
    );

    tss_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (qvalid),
        .i_q_item   (qb_item),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_found    (o_m_tuser),
        .o_left     (left),
        .o_right    (right)
    );

    assign o_m_tdata = {right, left};

endmodule
`default_nettype wire
